FILE: rtl/core/mqld_pkg.sv
// Package for the multi-queue link delay emulator core.
// Holds the shared codes, widths, the stored entry layout and the FSM states.
// No dependencies.
`timescale 1ns / 1ps

package mqld_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 8;
  localparam int REL_CNT_W       = 4;

  // bits per millisecond factor: 1000 ms per second times 8 bits per byte
  localparam logic [12:0] BITS_PER_MS = 13'd8000;
  localparam logic [15:0] MIN_DELAY_RESET = 16'd10;

  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] ST_QUEUED = 2'd0;
  localparam logic [1:0] ST_BYPASS = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  typedef struct packed {
    logic [31:0] delay;
    logic [15:0] len;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ENQ,
    S_SCAN,
    S_FIND,
    S_RDHEAD,
    S_LOAD
  } state_t;

endpackage

FILE: rtl/core/multi_queue_link_delay_emulator_core.sv
// Multi-queue link delay emulator: top level with the sequencer.
// Instantiates mqld_divider and mqld_queue_store; depends on mqld_pkg.
//
// Use: one input channel (in_valid / in_stall) carries enqueue and tick beats,
// one output channel (out_valid / out_stall) returns result beats, and a
// write-only cfg channel (cfg_valid / cfg_ready / cfg_data) sets min_delay_ms.
// An enqueue beat gives one status result: a start state (S_MUL) hands the
// 16x13 multiply to the serial divider, S_DIV waits for the quotient, then
// S_ENQ makes the queue decision; the sequencer then returns to idle for the
// next beat. A tick beat walks every queue once (S_SCAN) to age the head
// timers, then reads each released packet through the packet store's read
// port (S_FIND, S_RDHEAD, and S_LOAD while the queue holds more), passing
// over each queue that releases nothing; a tick with no release gives no
// result. One beat is worked on at a time; in_stall is high from acceptance
// until the sequencer is idle again, after its last result is in the output
// register.
// When the receiver stalls, the result holds and the sequencer waits on it.
// Synchronous reset empties all queues and sets min_delay_ms to 10; the
// packet store is not cleared and needs no sweep.
`timescale 1ns / 1ps

module multi_queue_link_delay_emulator_core #(
  parameter int NUM_QUEUES  = mqld_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [2:0]  queue_index,
  input  logic [15:0] packet_length,
  input  logic [29:0] link_speed,
  input  logic [15:0] packet_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [2:0]  out_queue,
  output logic [15:0] out_tag,
  output logic [15:0] out_length,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mqld_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = QW + PW;
  localparam int MDEPTH = 1 << AW;

  state_t state, state_next;

  // latched beat
  logic [2:0]  qin_r;
  logic [15:0] len_r;
  logic [29:0] speed_r;
  logic [15:0] tag_r;
  logic [31:0] dividend;
  logic [31:0] delay;

  logic [15:0] min_delay_ms;

  logic [31:0]   head_timer    [NUM_QUEUES];
  logic [PW-1:0] read_pointer  [NUM_QUEUES];
  logic [PW-1:0] write_pointer [NUM_QUEUES];
  logic [FW-1:0] fill_count    [NUM_QUEUES];

  logic [NUM_QUEUES-1:0] rel_mask;
  logic [REL_CNT_W-1:0]  rel_cnt;
  logic [REL_CNT_W-1:0]  emit_cnt;
  logic                  tick_done;
  logic [QW-1:0]         cur_q;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quot;
  logic [28:0] bits_ms;

  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t      mem_wdata;
  entry_t      mem_rdata;

  logic [31:0]   cur_timer;
  logic [FW-1:0] cur_fill;
  logic [PW-1:0] cur_rptr;
  logic [PW-1:0] cur_wptr;
  logic [PW-1:0] rptr_inc;
  logic [PW-1:0] wptr_inc;
  logic [FW-1:0] fill_dec;
  logic [31:0]   timer_dec;
  logic          scan_hit;
  logic [REL_CNT_W-1:0] rel_cnt_next;
  logic          last_rel;
  logic          scan_end;
  logic          idx_bad;
  logic [1:0]    enq_status;

  // per-queue view at the sequencer's queue
  always_comb begin
    cur_timer = head_timer[cur_q];
    cur_fill  = fill_count[cur_q];
    cur_rptr  = read_pointer[cur_q];
    cur_wptr  = write_pointer[cur_q];
    rptr_inc  = (cur_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_rptr + PW'(1);
    wptr_inc  = (cur_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_wptr + PW'(1);
    fill_dec  = cur_fill - FW'(1);
    timer_dec = (cur_timer == 32'd0) ? 32'd0 : cur_timer - 32'd1;
    scan_hit  = (cur_fill != '0) && (timer_dec == 32'd0) &&
                (rel_cnt < REL_CNT_W'(MAX_RESULTS));
    rel_cnt_next = rel_cnt + REL_CNT_W'(scan_hit);
    last_rel  = ((emit_cnt + REL_CNT_W'(1)) == rel_cnt);
    scan_end  = (cur_q == QW'(NUM_QUEUES - 1));
    idx_bad   = ({29'd0, qin_r} >= 32'(NUM_QUEUES));
  end

  // enqueue decision: bypass test before the queue checks
  always_comb begin
    if (delay < {16'd0, min_delay_ms}) begin
      enq_status = ST_BYPASS;
    end else if (idx_bad || (cur_fill >= FW'(QUEUE_DEPTH))) begin
      enq_status = ST_DROP;
    end else begin
      enq_status = ST_QUEUED;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign bits_ms   = 29'(len_r) * 29'(BITS_PER_MS);
  assign dividend  = {3'd0, bits_ms};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = (cmd == CMD_TICK) ? S_SCAN : S_MUL;
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_ENQ;
      S_ENQ:    if (out_free) state_next = S_IDLE;
      S_SCAN: begin
        if (scan_end) state_next = (rel_cnt_next == '0) ? S_IDLE : S_FIND;
      end
      S_FIND:   if (rel_mask[cur_q]) state_next = S_RDHEAD;
      S_RDHEAD: begin
        if (out_free) begin
          if (fill_dec != '0) state_next = S_LOAD;
          else state_next = last_rel ? S_IDLE : S_FIND;
        end
      end
      S_LOAD:   state_next = tick_done ? S_IDLE : S_FIND;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_MUL);
    mem_we    = (state == S_ENQ) && out_free && (enq_status == ST_QUEUED);
    mem_re    = 1'b0;
    mem_raddr = {cur_q, cur_rptr};
    out_load  = 1'b0;
    case (state)
      S_ENQ:  out_load = out_free;
      S_FIND: mem_re = rel_mask[cur_q];
      S_RDHEAD: begin
        out_load  = out_free;
        mem_re    = out_free && (fill_dec != '0);
        mem_raddr = {cur_q, rptr_inc};
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign mem_wdata = '{delay: delay, len: len_r, tag: tag_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay_ms <= MIN_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_delay_ms <= cfg_data;
    end
  end

  // latch the beat, take the delay
  always_ff @(posedge clk) begin
    if (accept) begin
      qin_r   <= queue_index;
      len_r   <= packet_length;
      speed_r <= link_speed;
      tag_r   <= packet_tag;
    end
    if ((state == S_DIV) && div_done) begin
      delay <= (speed_r == 30'd0) ? 32'hFFFF_FFFF : div_quot;
    end
  end

  // queue state and tick sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_timer[i]    <= 32'd0;
        read_pointer[i]  <= '0;
        write_pointer[i] <= '0;
        fill_count[i]    <= '0;
      end
      rel_mask  <= '0;
      rel_cnt   <= '0;
      emit_cnt  <= '0;
      tick_done <= 1'b0;
      cur_q     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rel_cnt  <= '0;
            emit_cnt <= '0;
            cur_q    <= (cmd == CMD_TICK) ? '0 : QW'(queue_index);
          end
        end
        S_ENQ: begin
          if (out_free && (enq_status == ST_QUEUED)) begin
            write_pointer[cur_q] <= wptr_inc;
            fill_count[cur_q]    <= cur_fill + FW'(1);
            if (cur_fill == '0) begin
              head_timer[cur_q] <= delay;
            end
          end
        end
        S_SCAN: begin
          if (cur_fill != '0) begin
            head_timer[cur_q] <= timer_dec;
          end
          if (scan_hit) begin
            rel_mask[cur_q] <= 1'b1;
          end
          rel_cnt <= rel_cnt_next;
          cur_q   <= scan_end ? '0 : cur_q + QW'(1);
        end
        S_FIND: begin
          if (!rel_mask[cur_q]) begin
            cur_q <= cur_q + QW'(1);
          end
        end
        S_RDHEAD: begin
          if (out_free) begin
            read_pointer[cur_q] <= rptr_inc;
            fill_count[cur_q]   <= fill_dec;
            rel_mask[cur_q]     <= 1'b0;
            emit_cnt            <= emit_cnt + REL_CNT_W'(1);
            tick_done           <= last_rel;
          end
        end
        S_LOAD: begin
          head_timer[cur_q] <= mem_rdata.delay;
        end
        default: begin
          tick_done <= tick_done;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_ENQ) begin
        kind       <= KIND_STATUS;
        status     <= enq_status;
        out_queue  <= qin_r;
        out_tag    <= tag_r;
        out_length <= len_r;
        last       <= 1'b1;
      end else begin
        kind       <= KIND_RELEASE;
        status     <= ST_QUEUED;
        out_queue  <= 3'(cur_q);
        out_tag    <= mem_rdata.tag;
        out_length <= mem_rdata.len;
        last       <= last_rel;
      end
    end
  end

  mqld_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (speed_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  mqld_queue_store #(
    .DEPTH (MDEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({cur_q, cur_wptr}),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  // no pending releases once the block is idle again
  a_mask_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (rel_mask == '0))
    else $error("release mask not empty in idle");

  // never more releases than the per-tick limit
  a_rel_limit: assert property (@(posedge clk) disable iff (rst)
    rel_cnt <= REL_CNT_W'(MAX_RESULTS))
    else $error("release count over limit");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // a release beat that is not last leaves more work in the tick
  a_rel_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && (state == S_RDHEAD) && !last_rel) |=> (state != S_IDLE))
    else $error("tick ended before its last release");

  // the queue written by an enqueue was not full
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (cur_fill < FW'(QUEUE_DEPTH)))
    else $error("write into a full queue");
`endif

endmodule

FILE: rtl/core/mqld_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Stand-alone: no package, no submodules.
`timescale 1ns / 1ps

module mqld_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [29:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  count;
  logic [29:0] rem;
  logic [31:0] quo;
  logic [29:0] dsr;
  logic [30:0] trial;
  logic        qbit;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[31]};
    qbit  = (trial >= {1'b0, dsr});
  end

  // step the division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 5'd0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == 5'd31);
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 30'd0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? 30'(trial - {1'b0, dsr}) : trial[29:0];
      quo <= {quo[30:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/core/mqld_queue_store.sv
// Packet store shared by all queues: one write port, one registered read port.
// Depends on mqld_pkg for the entry layout.
`timescale 1ns / 1ps

module mqld_queue_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mqld_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output mqld_pkg::entry_t rdata
);
  import mqld_pkg::*;

  entry_t mem [DEPTH];

  // write a beat's packet record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench for multi_queue_link_delay_emulator_core: directed and random beats
// checked against a per-queue delay predictor held in a small scoreboard class.
// Depends on mqld_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import mqld_pkg::*;

  localparam int NQ = 8;
  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [2:0]  q;
    logic [15:0] tag;
    logic [15:0] len;
    logic        last;
  } result_t;

  // Predict per-queue serialisation delays and hold the expected results
  class delay_scoreboard;
    entry_t      store[NQ][DEPTH];
    int unsigned timer[NQ];
    int unsigned rd_ptr[NQ];
    int unsigned wr_ptr[NQ];
    int unsigned fill[NQ];
    logic [15:0] min_delay;
    result_t     expected_q[$];
    int          errors;

    function new();
      min_delay = MIN_DELAY_RESET;
      errors = 0;
      for (int i = 0; i < NQ; i++) begin
        timer[i] = 0; rd_ptr[i] = 0; wr_ptr[i] = 0; fill[i] = 0;
      end
    endfunction

    function void set_min_delay(logic [15:0] v);
      min_delay = v;
    endfunction

    // Work out the results of one accepted beat
    function void note_beat(logic c, logic [2:0] qi, logic [15:0] len,
                            logic [29:0] speed, logic [15:0] tag);
      logic [31:0] bits_ms;
      logic [31:0] dly;
      result_t r;
      int n;
      if (c == CMD_ENQ) begin
        bits_ms = 32'(len) * 32'd8000;
        dly = (speed == 0) ? 32'hFFFF_FFFF : bits_ms / 32'(speed);
        r.kind = KIND_STATUS; r.q = qi; r.tag = tag; r.len = len; r.last = 1'b1;
        if (dly < 32'(min_delay)) r.status = ST_BYPASS;
        else if (fill[qi] >= DEPTH) r.status = ST_DROP;
        else begin
          store[qi][wr_ptr[qi]] = '{delay: dly, len: len, tag: tag};
          wr_ptr[qi] = (wr_ptr[qi] + 1) % DEPTH;
          if (fill[qi] == 0) timer[qi] = dly;
          fill[qi]++;
          r.status = ST_QUEUED;
        end
        expected_q.push_back(r);
      end else begin
        n = 0;
        for (int i = 0; i < NQ; i++) begin
          if (fill[i] == 0) continue;
          if (timer[i] > 0) timer[i]--;
          if (timer[i] == 0 && n < MAX_RESULTS) begin
            r.kind = KIND_RELEASE; r.status = ST_QUEUED; r.q = 3'(i);
            r.tag = store[i][rd_ptr[i]].tag; r.len = store[i][rd_ptr[i]].len;
            r.last = 1'b0;
            expected_q.push_back(r);
            n++;
            rd_ptr[i] = (rd_ptr[i] + 1) % DEPTH;
            fill[i]--;
            if (fill[i] != 0) timer[i] = store[i][rd_ptr[i]].delay;
          end
        end
        if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endfunction

    function void report(string what, result_t e, result_t a);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected k%0d s%0d q%0d t%h l%h last%0d, got k%0d s%0d q%0d t%h l%h last%0d",
                 what, e.kind, e.status, e.q, e.tag, e.len, e.last,
                 a.kind, a.status, a.q, a.tag, a.len, a.last);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(result_t a);
      result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected beat", '0, a);
        return;
      end
      e = expected_q.pop_front();
      if (a.kind !== e.kind) report("kind", e, a);
      else if (a.status !== e.status) report("status", e, a);
      else if (a.q !== e.q) report("queue", e, a);
      else if (a.tag !== e.tag) report("tag", e, a);
      else if (a.len !== e.len) report("length", e, a);
      else if (a.last !== e.last) report("last", e, a);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_ENQ;
  logic [2:0]  queue_index = '0;
  logic [15:0] packet_length = '0;
  logic [29:0] link_speed = 30'd1;
  logic [15:0] packet_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [1:0]  status;
  logic [2:0]  out_queue;
  logic [15:0] out_tag;
  logic [15:0] out_length;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  delay_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  multi_queue_link_delay_emulator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .queue_index(queue_index), .packet_length(packet_length),
    .link_speed(link_speed), .packet_tag(packet_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status), .out_queue(out_queue),
    .out_tag(out_tag), .out_length(out_length), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receive and check result beats; stall at random or hold off on request
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result('{kind: kind, status: status, q: out_queue, tag: out_tag,
                          len: out_length, last: last});
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat, idling first at random, and hold it until accepted
  task automatic send_beat(logic c, logic [2:0] qi, logic [15:0] len,
                           logic [29:0] speed, logic [15:0] tag);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c; queue_index <= qi; packet_length <= len;
    link_speed <= speed; packet_tag <= tag;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(c, qi, len, speed, tag);
  endtask

  task automatic random_beat();
    logic [15:0] len;
    logic [29:0] speed;
    int unsigned target;
    len = 16'($urandom);
    if ($urandom_range(99) < 35) begin
      send_beat(CMD_TICK, 3'($urandom), len, 30'($urandom), 16'($urandom));
    end else begin
      // mostly delays of a few tens of ms; sometimes any speed at all
      if ($urandom_range(99) < 12) begin
        speed = 30'($urandom);
      end else begin
        target = $urandom_range(1, 30);
        speed = 30'((32'(len) * 32'd8000) / target + $urandom_range(0, 3));
        if (speed == 0) speed = 30'($urandom_range(1, 1000));
      end
      send_beat(CMD_ENQ, 3'($urandom), len, speed, 16'($urandom));
    end
  endtask

  // Let the block drain before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_delay(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_min_delay(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tick on empty queues, bypasses at the field extremes
    send_beat(CMD_TICK, 3'd0, 16'd0, 30'd1, 16'd0);
    send_beat(CMD_ENQ, 3'd0, 16'd0, 30'd1, 16'h0000);
    send_beat(CMD_ENQ, 3'd1, 16'hFFFF, 30'h3FFF_FFFF, 16'hFFFF);
    send_beat(CMD_ENQ, 3'd2, 16'd1, 30'd400, 16'h5A5A);
    // Fill one queue, then a zero-speed packet into the full queue is dropped
    for (int i = 0; i < DEPTH; i++)
      send_beat(CMD_ENQ, 3'd7, 16'd100, 30'd66666, 16'(16'hA000 + i));
    send_beat(CMD_ENQ, 3'd7, 16'd1234, 30'd0, 16'hDEAD);
    repeat (3) send_beat(CMD_TICK, 3'd0, 16'd0, 30'd1, 16'd0);

    // Random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle = 0; recv_idle = 0;
          hold_left = HOLD_CYCLES;
        end
        1: begin
          wait_drained(); write_min_delay(16'd0);
          send_idle = 83; recv_idle = 0;
        end
        2: begin
          wait_drained(); write_min_delay(16'hFFFF);
          send_idle = 0; recv_idle = 83;
        end
        default: begin
          wait_drained(); write_min_delay(16'($urandom_range(1, 25)));
          send_idle = 28; recv_idle = 28;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_beat();
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
